FILE: hdl/rsdv_pkg.sv
// shared types, constants and helper functions of the rotation sensor decoder
package rsdv_pkg;

   localparam int CHANNELS    = 3;
   localparam int SPEED_SCALE = 1000;
   localparam int TIMEOUT_MS  = 1000;
   localparam int SPEED_MAX   = 1023;

   localparam int CH_IN_W = 2;
   localparam int CH_W    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int QW      = $clog2(SPEED_SCALE + 1);
   localparam int DT_W    = $clog2(TIMEOUT_MS + 1);
   localparam int CNT_W   = (QW > 1) ? $clog2(QW) : 1;

   localparam int REQ_TDATA_W = 56;
   localparam int RSP_TDATA_W = 32;
   localparam int CSR_ADDR_W  = 3;

   localparam logic REG_CHANNEL_ENABLE = 1'b0;

   localparam logic       FUNC_SAMPLE = 1'b0;
   localparam logic       FUNC_SET    = 1'b1;
   localparam logic [1:0] DIR_NONE    = 2'b00;
   localparam logic [1:0] DIR_FWD     = 2'b01;
   localparam logic [1:0] DIR_REV     = 2'b11;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_LOAD,
      ST_DIV,
      ST_FIN
   } st_type;

   typedef struct packed {
      logic [1:0]  phase;
      logic [15:0] position;
      logic [10:0] speed;
      logic [1:0]  dir;
      logic [15:0] last_time;
      logic [15:0] next_time;
   } entry_type;

   // {invalid, phase} for the top nibble of a sample
   function automatic logic [2:0] nibble_phase(input logic [3:0] nib);
      logic [2:0] r;
      unique case (nib)
         4'd5, 4'd6, 4'd7:          r = 3'b010;
         4'd8, 4'd9, 4'd10, 4'd11:  r = 3'b011;
         4'd12, 4'd13, 4'd14:       r = 3'b001;
         4'd15:                     r = 3'b000;
         default:                   r = 3'b100;
      endcase
      return r;
   endfunction

   // step as a 2-bit signed value from new and old phase
   function automatic logic [1:0] phase_step(input logic [1:0] np, input logic [1:0] op);
      logic [1:0] d;
      logic [1:0] r;
      d = np - op;
      unique case (d)
         2'd1:    r = DIR_FWD;
         2'd3:    r = DIR_REV;
         default: r = DIR_NONE;
      endcase
      return r;
   endfunction

   // saturated magnitude with sign applied
   function automatic logic [10:0] signed_speed(input logic [QW-1:0] mag, input logic neg);
      logic [9:0] m;
      m = (32'(mag) > SPEED_MAX) ? 10'(SPEED_MAX) : 10'(mag);
      return neg ? (11'd0 - {1'b0, m}) : {1'b0, m};
   endfunction

endpackage

FILE: hdl/rotation_sensor_decoder_velocity.sv
// top level: per-channel rotation phase tracking, position count and velocity estimate
// One word is taken at a time. A set word, a word on a disabled or missing channel, and a
// sample that needs no new speed pass from acceptance through the load and finish states;
// a sample that needs a new speed also passes through the 10-step restoring divider that
// forms 1000 / interval. A new word is taken only after the result has been loaded into
// the output register. A stalled result holds the block in its last step. The per-channel
// state sits in a 3-entry memory read at acceptance and written back when the result is
// loaded into the output register; entries never written since reset read as zero. csr
// register 0 at address 0 holds the channel enable mask.
module rotation_sensor_decoder_velocity (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // channel[1:0], raw_sample[17:2], now_ms[33:18], set_position[49:34], zero pad
   input  logic [rsdv_pkg::REQ_TDATA_W-1:0]    req_tdata,
   // func
   input  logic                                req_tuser,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // out_channel[1:0], position_count[17:2], velocity[28:18], zero pad
   output logic [rsdv_pkg::RSP_TDATA_W-1:0]    rsp_tdata,
   // tracked
   output logic                                rsp_tuser,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [rsdv_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  logic [31:0]                         csr_pwdata,
   output logic [31:0]                         csr_prdata,
   output logic                                csr_pready
);
   import rsdv_pkg::*;

   st_type state_ff, state_in;

   logic [CHANNELS-1:0] mask_ff;
   logic [CHANNELS-1:0] valid_ff;
   entry_type           state_mem [0:CHANNELS-1];
   entry_type           rd_ff;
   logic                rd_valid_ff;

   logic                func_ff;
   logic [CH_IN_W-1:0]  ch_ff;
   logic [3:0]          nib_ff;
   logic [15:0]         now_ff;
   logic [15:0]         setpos_ff;
   logic                exists_ff;
   logic                en_ff;

   entry_type           wk_ff, wk_in;
   logic                div_ff, div_in;
   logic                neg_ff, neg_in;
   logic [DT_W-1:0]     dvs_ff, dvs_in;
   logic [DT_W-1:0]     rem_ff;
   logic [QW-1:0]       quo_ff;
   logic [CNT_W-1:0]    cnt_ff;

   logic                rsp_tvalid_ff;
   logic [RSP_TDATA_W-1:0] rsp_tdata_ff;
   logic                rsp_tuser_ff;

   logic                accept;
   logic                fin_go;
   logic                div_last;
   logic [CH_IN_W-1:0]  req_ch;
   logic                req_exists;
   logic [(1 << CH_IN_W)-1:0] mask_ext;
   logic                csr_wr;

   entry_type           ent;
   logic [2:0]          np_raw;
   logic [1:0]          step;
   logic [15:0]         dt;
   logic [15:0]         late;

   logic [DT_W:0]       trial;
   logic                qbit;
   logic [10:0]         final_speed;

   // config port
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   always_comb begin
      csr_prdata = '0;
      if (csr_paddr[2] == REG_CHANNEL_ENABLE) begin
         csr_prdata = 32'(mask_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mask_ff <= '0;
      end else if (csr_wr && csr_paddr[2] == REG_CHANNEL_ENABLE) begin
         mask_ff <= csr_pwdata[CHANNELS-1:0];
      end
   end

   // input decode
   assign req_ch     = req_tdata[1:0];
   assign req_exists = 32'(req_ch) < CHANNELS;
   assign mask_ext   = (1 << CH_IN_W)'(mask_ff);
   assign accept     = req_tvalid && req_tready;

   // state machine
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      req_tready = 1'b0;
      fin_go     = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               state_in = ST_LOAD;
            end
         end
         ST_LOAD: begin
            state_in = div_in ? ST_DIV : ST_FIN;
         end
         ST_DIV: begin
            if (div_last) begin
               state_in = ST_FIN;
            end
         end
         ST_FIN: begin
            if (!rsp_tvalid_ff || rsp_tready) begin
               fin_go   = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // capture and memory read
   always_ff @(posedge clock) begin
      if (accept) begin
         func_ff   <= req_tuser;
         ch_ff     <= req_ch;
         nib_ff    <= req_tdata[17:14];
         now_ff    <= req_tdata[33:18];
         setpos_ff <= req_tdata[49:34];
         exists_ff <= req_exists;
         en_ff     <= req_exists && mask_ext[req_ch];
         if (req_exists) begin
            rd_ff       <= state_mem[req_ch[CH_W-1:0]];
            rd_valid_ff <= valid_ff[req_ch[CH_W-1:0]];
         end else begin
            rd_valid_ff <= 1'b0;
         end
      end
   end

   // update of the entry
   always_comb begin
      ent    = rd_valid_ff ? rd_ff : '0;
      np_raw = nibble_phase(nib_ff);
      step   = np_raw[2] ? DIR_NONE : phase_step(np_raw[1:0], ent.phase);
      dt     = now_ff - ent.last_time;
      late   = now_ff - ent.next_time;
      wk_in  = ent;
      div_in = 1'b0;
      neg_in = 1'b0;
      dvs_in = dt[DT_W-1:0];
      if (exists_ff) begin
         if (func_ff == FUNC_SET) begin
            wk_in.phase    = np_raw[2] ? 2'd0 : np_raw[1:0];
            wk_in.position = setpos_ff;
         end else if (en_ff) begin
            if (step != DIR_NONE) begin
               wk_in.position = ent.position + {{14{step[1]}}, step};
               wk_in.phase    = np_raw[1:0];
               if (step != ent.dir) begin
                  wk_in.dir       = step;
                  wk_in.speed     = '0;
                  wk_in.last_time = now_ff;
                  wk_in.next_time = now_ff + 16'(TIMEOUT_MS);
               end else if (dt == 16'd0) begin
                  wk_in.speed = signed_speed(QW'(SPEED_SCALE), step[1]);
               end else if (32'(dt) > TIMEOUT_MS) begin
                  wk_in.dir   = DIR_NONE;
                  wk_in.speed = '0;
               end else begin
                  div_in          = 1'b1;
                  neg_in          = step[1];
                  wk_in.last_time = now_ff;
                  wk_in.next_time = now_ff + dt + {1'b0, dt[15:1]};
               end
            end else if (ent.dir != DIR_NONE && !late[15]) begin
               if (32'(dt) > TIMEOUT_MS) begin
                  wk_in.dir   = DIR_NONE;
                  wk_in.speed = '0;
               end else if (dt == 16'd0) begin
                  wk_in.speed     = signed_speed(QW'(SPEED_SCALE), ent.dir[1]);
                  wk_in.next_time = now_ff;
               end else begin
                  div_in          = 1'b1;
                  neg_in          = ent.dir[1];
                  wk_in.next_time = now_ff + {1'b0, dt[15:1]};
               end
            end
         end
      end
   end

   // restoring divider of the speed scale by the step interval
   assign trial    = {rem_ff, quo_ff[QW-1]};
   assign qbit     = trial >= {1'b0, dvs_ff};
   assign div_last = cnt_ff == CNT_W'(QW - 1);

   always_ff @(posedge clock) begin
      if (state_ff == ST_LOAD) begin
         wk_ff  <= wk_in;
         div_ff <= div_in;
         neg_ff <= neg_in;
         dvs_ff <= dvs_in;
         rem_ff <= '0;
         quo_ff <= QW'(SPEED_SCALE);
         cnt_ff <= '0;
      end else if (state_ff == ST_DIV) begin
         rem_ff <= qbit ? DT_W'(trial - {1'b0, dvs_ff}) : trial[DT_W-1:0];
         quo_ff <= {quo_ff[QW-2:0], qbit};
         cnt_ff <= cnt_ff + CNT_W'(1);
      end
   end

   assign final_speed = div_ff ? signed_speed(quo_ff, neg_ff) : wk_ff.speed;

   // write back
   always_ff @(posedge clock) begin
      if (fin_go && exists_ff) begin
         state_mem[ch_ff[CH_W-1:0]] <= '{phase:     wk_ff.phase,
                                        position:  wk_ff.position,
                                        speed:     final_speed,
                                        dir:       wk_ff.dir,
                                        last_time: wk_ff.last_time,
                                        next_time: wk_ff.next_time};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (fin_go && exists_ff) begin
         valid_ff[ch_ff[CH_W-1:0]] <= 1'b1;
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid_ff <= 1'b0;
      end else if (fin_go) begin
         rsp_tvalid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_tvalid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (fin_go) begin
         rsp_tdata_ff <= exists_ff ? RSP_TDATA_W'({final_speed, wk_ff.position, ch_ff})
                                   : RSP_TDATA_W'(ch_ff);
         rsp_tuser_ff <= en_ff;
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;
   assign rsp_tuser  = rsp_tuser_ff;

endmodule
